@@ src/cpef_pkg.sv @@
package cpef_pkg;

    localparam int unsigned SLOT_W   = 16;
    localparam int unsigned TAG_W    = 8;
    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BLEN_W   = 4;

    // constant pool tag codes
    localparam logic [TAG_W-1:0] TAG_UTF8         = 8'd1;
    localparam logic [TAG_W-1:0] TAG_INTEGER      = 8'd3;
    localparam logic [TAG_W-1:0] TAG_FLOAT        = 8'd4;
    localparam logic [TAG_W-1:0] TAG_LONG         = 8'd5;
    localparam logic [TAG_W-1:0] TAG_DOUBLE       = 8'd6;
    localparam logic [TAG_W-1:0] TAG_CLASS        = 8'd7;
    localparam logic [TAG_W-1:0] TAG_STRING       = 8'd8;
    localparam logic [TAG_W-1:0] TAG_FIELDREF     = 8'd9;
    localparam logic [TAG_W-1:0] TAG_METHODREF    = 8'd10;
    localparam logic [TAG_W-1:0] TAG_IFMETHODREF  = 8'd11;
    localparam logic [TAG_W-1:0] TAG_NAMEANDTYPE  = 8'd12;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
    } in_word_t;

    typedef struct packed {
        logic                in_pool;
        logic [SLOT_W-1:0]   slot_index;
        logic [TAG_W-1:0]    entry_tag;
        logic [OFFSET_W-1:0] byte_offset;
        logic [BYTE_W-1:0]   byte_value;
        logic                last_of_entry;
        logic                pool_done;
        logic                bad_tag;
    } result_t;

    // body length in bytes after the tag; zero flags an unknown tag
    function automatic logic [BLEN_W-1:0] body_len(input logic [TAG_W-1:0] tag);
        logic [BLEN_W-1:0] len;
        begin
            len = '0;
            unique case (tag)
                TAG_CLASS, TAG_STRING, TAG_UTF8: len = 4'd2;
                TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF,
                TAG_INTEGER, TAG_FLOAT, TAG_NAMEANDTYPE: len = 4'd4;
                TAG_LONG, TAG_DOUBLE: len = 4'd8;
                default: len = '0;
            endcase
            return len;
        end
    endfunction

endpackage

@@ src/cpef_in_stage.sv @@
module cpef_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpef_pkg::in_word_t in_word,
    input  logic               take,
    output logic               held_valid,
    output cpef_pkg::in_word_t held_word
);
    import cpef_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

@@ src/cpef_core.sv @@
module cpef_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  cpef_pkg::in_word_t        word,
    input  logic [cpef_pkg::SLOT_W-1:0] entry_count,
    output cpef_pkg::result_t         result
);
    import cpef_pkg::*;

    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [TAG_W-1:0]    tag_reg,    tag_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [OFFSET_W-1:0] blen_reg,   blen_next;
    logic [BYTE_W-1:0]   lenhi_reg,  lenhi_next;
    logic                active_reg, active_next;
    logic                error_reg,  error_next;

    logic [OFFSET_W-1:0] blen_now;
    logic [BLEN_W-1:0]   tag_len;
    logic [SLOT_W:0]     slot_step;
    logic [BYTE_W-1:0]   b;

    assign b = word.data_byte;

    always_comb
    begin
        // a restart word clears the framer before it is looked at
        slot_next   = word.first_byte ? SLOT_W'(1) : slot_reg;
        offset_next = word.first_byte ? '0 : offset_reg;
        blen_next   = word.first_byte ? '0 : blen_reg;
        lenhi_next  = word.first_byte ? '0 : lenhi_reg;
        error_next  = word.first_byte ? 1'b0 : error_reg;
        active_next = word.first_byte ? (entry_count > SLOT_W'(1)) : active_reg;
        tag_next    = tag_reg;
        tag_len     = body_len(b);
        blen_now    = blen_next;
        slot_step   = '0;

        result               = '0;
        result.byte_value    = b;

        if (active_next)
        begin
            if (offset_next == '0)
            begin
                result.slot_index = slot_next;
                result.entry_tag  = b;
                if (tag_len == '0)
                begin
                    error_next  = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    result.in_pool = 1'b1;
                    tag_next       = b;
                    blen_next      = OFFSET_W'(tag_len);
                    offset_next    = OFFSET_W'(1);
                end
            end
            else
            begin
                result.in_pool     = 1'b1;
                result.slot_index  = slot_next;
                result.entry_tag   = tag_reg;
                result.byte_offset = offset_next;
                // utf-8 length arrives big-endian in body bytes one and two
                if (tag_reg == TAG_UTF8)
                begin
                    if (offset_next == OFFSET_W'(1))
                    begin
                        lenhi_next = b;
                    end
                    else if (offset_next == OFFSET_W'(2))
                    begin
                        blen_now = OFFSET_W'(2) + {1'b0, lenhi_next, b};
                    end
                end
                blen_next = blen_now;
                if (offset_next >= blen_now)
                begin
                    slot_step = {1'b0, slot_next} +
                        (((tag_reg == TAG_LONG) || (tag_reg == TAG_DOUBLE)) ?
                         (SLOT_W+1)'(2) : (SLOT_W+1)'(1));
                    result.last_of_entry = 1'b1;
                    offset_next          = '0;
                    if (slot_step >= {1'b0, entry_count})
                    begin
                        result.pool_done = 1'b1;
                        active_next      = 1'b0;
                    end
                    slot_next = slot_step[SLOT_W-1:0];
                end
                else
                begin
                    offset_next = offset_next + OFFSET_W'(1);
                end
            end
        end
        result.bad_tag = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= SLOT_W'(1);
            tag_reg    <= '0;
            offset_reg <= '0;
            blen_reg   <= '0;
            lenhi_reg  <= '0;
            active_reg <= 1'b0;
            error_reg  <= 1'b0;
        end
        else if (advance)
        begin
            slot_reg   <= slot_next;
            tag_reg    <= tag_next;
            offset_reg <= offset_next;
            blen_reg   <= blen_next;
            lenhi_reg  <= lenhi_next;
            active_reg <= active_next;
            error_reg  <= error_next;
        end
    end

endmodule

@@ src/cpef_out_stage.sv @@
module cpef_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cpef_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output cpef_pkg::result_t out_word
);
    import cpef_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            word_reg <= result;
        end
    end

endmodule

@@ src/constant_pool_entry_framer.sv @@
// channel   dir  signals                         content
// s_axis    in   tvalid tready tdata[7:0] tuser  raw class-file byte, restart flag
// m_axis    out  tvalid tready tdata[55:0] tuser tlast  framed byte with slot/tag/offset
// cfg       in   cfg_wr_en cfg_wr_data[15:0]     constant pool count
//
// one byte a cycle sustained while the output side takes words; each byte passes
// through the input register and the result register, with the tag decode and
// the slot/offset counters in between.
// rst_n clears all control state: slot one, framing idle, error clear, count one.
// a stalled output holds its word; the input register and the result register
// keep taking words as long as the word ahead of them moves on.
module constant_pool_entry_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_index[15:0], entry_tag[23:16], byte_offset[40:24], byte_value[48:41], zero
    output logic [55:0] m_axis_tdata,
    // in_pool, pool_done, bad_tag
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast    // last_of_entry
);
    import cpef_pkg::*;

    logic [SLOT_W-1:0] entry_count_reg;
    in_word_t          in_word;
    in_word_t          held_word;
    logic              held_valid;
    logic              can_load;
    logic              advance;
    result_t           result;
    result_t           out_word;

    assign in_word.data_byte  = s_axis_tdata;
    assign in_word.first_byte = s_axis_tuser;
    assign advance            = held_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= SLOT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    cpef_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .take       (can_load),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    cpef_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .word        (held_word),
        .entry_count (entry_count_reg),
        .result      (result)
    );

    cpef_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (held_valid),
        .result    (result),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {7'd0, out_word.byte_value, out_word.byte_offset,
                           out_word.entry_tag, out_word.slot_index};
    assign m_axis_tuser = {out_word.bad_tag, out_word.pool_done, out_word.in_pool};
    assign m_axis_tlast = out_word.last_of_entry;

endmodule

@@ bench/pool_frame_checker.sv @@
`timescale 1ns / 1ps

// watches both streams, predicts every framed word and compares in order
module pool_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          pending,
    output int          errors
);
    import cpef_pkg::*;

    result_t             expected_words[$];
    int                  mismatch_count;
    int                  words_seen;

    // shadow of the framer state
    logic [SLOT_W-1:0]   pool_count;
    logic [SLOT_W-1:0]   slot_ctr;
    logic [TAG_W-1:0]    cur_tag;
    logic [OFFSET_W-1:0] off_ctr;
    logic [OFFSET_W-1:0] entry_len;
    logic [7:0]          len_high;
    logic                framing;
    logic                tag_error;

    result_t             got;
    result_t             want;

    function automatic logic [OFFSET_W-1:0] body_bytes_for(input logic [TAG_W-1:0] tag);
        case (tag)
            TAG_CLASS, TAG_STRING, TAG_UTF8:
                return 17'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFMETHODREF, TAG_NAMEANDTYPE:
                return 17'd4;
            TAG_LONG, TAG_DOUBLE:
                return 17'd8;
            default:
                return 17'd0;
        endcase
    endfunction

    function automatic result_t frame_byte(input logic [7:0] b, input logic first);
        result_t             r;
        logic [OFFSET_W-1:0] len;
        logic [SLOT_W:0]     nxt;
        r = '0;
        r.byte_value = b;
        if (first)
        begin
            tag_error = 1'b0;
            slot_ctr  = 16'd1;
            off_ctr   = '0;
            entry_len = '0;
            len_high  = '0;
            framing   = (pool_count > 16'd1);
        end
        if (!framing)
        begin
            r.bad_tag = tag_error;
            return r;
        end
        if (off_ctr == '0)
        begin
            len = body_bytes_for(b);
            r.slot_index = slot_ctr;
            r.entry_tag  = b;
            if (len == '0)
            begin
                tag_error = 1'b1;
                framing   = 1'b0;
                r.bad_tag = 1'b1;
                return r;
            end
            cur_tag   = b;
            entry_len = len;
            off_ctr   = 17'd1;
            r.in_pool = 1'b1;
            return r;
        end
        // utf8 length arrives big-endian in the first two body bytes
        if (cur_tag == TAG_UTF8)
        begin
            if (off_ctr == 17'd1)
                len_high = b;
            else if (off_ctr == 17'd2)
                entry_len = 17'd2 + {1'b0, len_high, b};
        end
        r.in_pool     = 1'b1;
        r.slot_index  = slot_ctr;
        r.entry_tag   = cur_tag;
        r.byte_offset = off_ctr;
        if (off_ctr >= entry_len)
        begin
            nxt = {1'b0, slot_ctr} +
                  (((cur_tag == TAG_LONG) || (cur_tag == TAG_DOUBLE)) ? 17'd2 : 17'd1);
            r.last_of_entry = 1'b1;
            off_ctr = '0;
            if (nxt >= {1'b0, pool_count})
            begin
                r.pool_done = 1'b1;
                framing     = 1'b0;
            end
            slot_ctr = nxt[SLOT_W-1:0];
        end
        else
        begin
            off_ctr = off_ctr + 17'd1;
        end
        r.bad_tag = tag_error;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            mismatch_count = 0;
            words_seen     = 0;
            pool_count     = 16'd1;
            slot_ctr       = 16'd1;
            cur_tag        = '0;
            off_ctr        = '0;
            entry_len      = '0;
            len_high       = '0;
            framing        = 1'b0;
            tag_error      = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                pool_count = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.in_pool       = m_axis_tuser[0];
                got.pool_done     = m_axis_tuser[1];
                got.bad_tag       = m_axis_tuser[2];
                got.last_of_entry = m_axis_tlast;
                got.slot_index    = m_axis_tdata[15:0];
                got.entry_tag     = m_axis_tdata[23:16];
                got.byte_offset   = m_axis_tdata[40:24];
                got.byte_value    = m_axis_tdata[48:41];
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d arrived with nothing expected", words_seen);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch on word %0d", words_seen);
                            $write("  expected in=%b slot=%0d tag=%0d off=%0d",
                                   want.in_pool, want.slot_index, want.entry_tag,
                                   want.byte_offset);
                            $display(" val=%0d last=%b done=%b bad=%b",
                                     want.byte_value, want.last_of_entry,
                                     want.pool_done, want.bad_tag);
                            $write("  actual   in=%b slot=%0d tag=%0d off=%0d",
                                   got.in_pool, got.slot_index, got.entry_tag,
                                   got.byte_offset);
                            $display(" val=%0d last=%b done=%b bad=%b",
                                     got.byte_value, got.last_of_entry,
                                     got.pool_done, got.bad_tag);
                        end
                    end
                end
                words_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(frame_byte(s_axis_tdata, s_axis_tuser));
        end
        pending <= expected_words.size();
        errors  <= mismatch_count;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import cpef_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 1250;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          pending;
    int          errors;

    int          burst_left = 0;
    int          bytes_sent = 0;
    int unsigned live_count = 1;
    bit          hold_req = 1'b0;
    bit          hold_served = 1'b0;

    logic [7:0]  known_tags [11] = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE,
                                     TAG_CLASS, TAG_STRING, TAG_FIELDREF, TAG_METHODREF,
                                     TAG_IFMETHODREF, TAG_NAMEANDTYPE};

    constant_pool_entry_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pool_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending),
        .errors        (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one word through the input side, with bursts and gaps
    task automatic send_word(input logic [7:0] b, input logic first);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // only written with the framer drained
    task automatic write_count(input logic [15:0] value);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        live_count  = {16'd0, value};
    endtask

    task automatic send_entry(input logic [7:0] tag, input logic restart,
                              input int unsigned utf_len, input int unsigned keep);
        int unsigned body;
        logic [7:0]  b;
        send_word(tag, restart);
        case (tag)
            TAG_UTF8:
                body = utf_len + 2;
            TAG_CLASS, TAG_STRING:
                body = 2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFMETHODREF, TAG_NAMEANDTYPE:
                body = 4;
            TAG_LONG, TAG_DOUBLE:
                body = 8;
            default:
                body = $urandom_range(0, 5);
        endcase
        if (keep < body)
            body = keep;
        for (int unsigned k = 0; k < body; k++)
        begin
            if (tag == TAG_UTF8 && k == 0)
                b = utf_len[15:8];
            else if (tag == TAG_UTF8 && k == 1)
                b = utf_len[7:0];
            else
                b = 8'($urandom_range(0, 255));
            send_word(b, 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_tag();
        if ($urandom_range(0, 19) < 17)
            return known_tags[4'($urandom_range(0, 10))];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_utf_len();
        int unsigned r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return $urandom_range(256, 700);
        if (r < 5)
            return $urandom_range(13, 255);
        return $urandom_range(0, 12);
    endfunction

    // one pool: restart, a run of entries, sometimes cut short, sometimes stray bytes after
    task automatic random_pool();
        int          n_entries;
        int unsigned keep;
        int unsigned r;
        if ($urandom_range(0, 1) == 1)
        begin
            r = $urandom_range(0, 19);
            case (r)
                0:       write_count(16'd0);
                1:       write_count(16'd1);
                2:       write_count(16'hFFFF);
                3:       write_count(16'd2);
                4:       write_count(16'($urandom_range(15, 40)));
                default: write_count(16'($urandom_range(2, 14)));
            endcase
        end
        if (live_count <= 1)
            n_entries = $urandom_range(1, 2);
        else
            n_entries = $urandom_range(1, (live_count > 20) ? 20 : live_count + 1);
        for (int i = 0; i < n_entries; i++)
        begin
            keep = 32'hFFFF_FFFF;
            if (i == n_entries - 1 && $urandom_range(0, 7) == 0)
                keep = $urandom_range(0, 3);
            send_entry(pick_tag(), i == 0, pick_utf_len(), keep);
            if (bytes_sent >= RANDOM_BYTES / 2)
                hold_req = 1'b1;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // receiver: stretches of differing readiness, plus one long hold-off
    initial
    begin
        int mode;
        int span;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_req && !hold_served)
                begin
                    hold_served   = 1'b1;
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ~m_axis_tready;
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // count still at its reset value of one: restart frames nothing
        send_word(TAG_CLASS, 1'b1);
        send_word(8'h55, 1'b0);

        // two-slot entry in the only slot ends the pool
        write_count(16'd2);
        send_entry(TAG_LONG, 1'b1, 0, 32'hFFFF_FFFF);

        write_count(16'hFFFF);
        send_word(TAG_CLASS, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        // empty utf8 string
        send_word(TAG_UTF8, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        // unknown tag, then a byte seen while the error sticks
        send_word(8'h00, 1'b0);
        send_word(8'hAB, 1'b0);
        // restart straight onto an unknown tag
        send_word(8'hFF, 1'b1);
        // restart in the middle of an entry
        send_word(TAG_INTEGER, 1'b1);
        send_word(8'h12, 1'b0);
        send_entry(TAG_DOUBLE, 1'b1, 0, 32'hFFFF_FFFF);

        // zero count: empty pool on restart
        write_count(16'd0);
        send_word(TAG_UTF8, 1'b1);

        // utf8 entry with both length bytes in use
        write_count(16'hFFFF);
        send_entry(TAG_UTF8, 1'b1, 260, 32'hFFFF_FFFF);
        send_entry(TAG_NAMEANDTYPE, 1'b0, 0, 32'hFFFF_FFFF);

        while (bytes_sent < RANDOM_BYTES)
            random_pool();

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
